>>> design/rdd_pkg.sv
// Shared types and constants for the resource deadlock detector.
// No dependencies; used by the controller, datapath and top level by scoped names.
package rdd_pkg;

  localparam int PROC_NUM   = 16;
  localparam int RES_NUM    = 16;
  localparam int COUNT_BITS = 8;
  localparam int P_BITS     = $clog2(PROC_NUM);
  localparam int R_BITS     = $clog2(RES_NUM);
  localparam int ADDR_BITS  = P_BITS + R_BITS;
  localparam int TABLE_DEPTH = PROC_NUM * RES_NUM;
  // Saturated counts span 0..16, so one bit more than an index.
  localparam int CFG_BITS   = 5;
  // Sum of PROC_NUM allocations of COUNT_BITS each.
  localparam int USED_BITS  = COUNT_BITS + P_BITS;
  localparam int REQ_BITS   = R_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_PROCESS_COUNT  = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_SET_TOTAL = 2'd0,
    OP_SET_ALLOC = 2'd1,
    OP_SET_REQ   = 2'd2,
    OP_RUN       = 2'd3
  } op_t;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_SUM       = 10'b00_0000_0010,
    ST_SUM_DRAIN = 10'b00_0000_0100,
    ST_MARK      = 10'b00_0000_1000,
    ST_SCAN      = 10'b00_0001_0000,
    ST_RELEASE   = 10'b00_0010_0000,
    ST_ADVANCE   = 10'b00_0100_0000,
    ST_CHECK     = 10'b00_1000_0000,
    ST_EMIT      = 10'b01_0000_0000,
    ST_EMIT_NONE = 10'b10_0000_0000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic run_start;
    logic sum_issue;
    logic mark;
    logic scan;
    logic rel_issue;
    logic p_advance;
    logic pass_restart;
    logic emit_init;
    logic out_load;
    logic out_found;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic np_zero;
    logic nr_zero;
    logic sum_last;
    logic candidate;
    logic r_last;
    logic p_last;
    logic changed;
    logic deadlock;
    logic cur_unf;
    logic last_unf;
    logic out_space;
  } stat_t;

endpackage

>>> design/rdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/rdd_ctrl.sv
// Controller state machine of the deadlock detector.
// Depends on rdd_pkg for the state, command and status types.
module rdd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic [1:0]     s_tuser,
  output logic           s_tready,
  input  rdd_pkg::stat_t stat,
  output rdd_pkg::cmd_t  cmd
);

  rdd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      rdd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (rdd_pkg::op_t'(s_tuser) == rdd_pkg::OP_RUN) begin
            cmd.run_start = 1'b1;
            // nothing to sum when either count is zero
            state_next = (stat.np_zero || stat.nr_zero) ? rdd_pkg::ST_SUM_DRAIN
                                                        : rdd_pkg::ST_SUM;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      rdd_pkg::ST_SUM: begin
        cmd.sum_issue = 1'b1;
        if (stat.sum_last) begin
          state_next = rdd_pkg::ST_SUM_DRAIN;
        end
      end
      rdd_pkg::ST_SUM_DRAIN: begin
        state_next = rdd_pkg::ST_MARK;
      end
      rdd_pkg::ST_MARK: begin
        cmd.mark = 1'b1;
        state_next = stat.np_zero ? rdd_pkg::ST_CHECK : rdd_pkg::ST_SCAN;
      end
      rdd_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        state_next = (stat.candidate && !stat.nr_zero) ? rdd_pkg::ST_RELEASE
                                                       : rdd_pkg::ST_ADVANCE;
      end
      rdd_pkg::ST_RELEASE: begin
        cmd.rel_issue = 1'b1;
        if (stat.r_last) begin
          state_next = rdd_pkg::ST_ADVANCE;
        end
      end
      rdd_pkg::ST_ADVANCE: begin
        if (!stat.p_last) begin
          cmd.p_advance = 1'b1;
          state_next = rdd_pkg::ST_SCAN;
        end else if (stat.changed) begin
          cmd.pass_restart = 1'b1;
          state_next = rdd_pkg::ST_SCAN;
        end else begin
          state_next = rdd_pkg::ST_CHECK;
        end
      end
      rdd_pkg::ST_CHECK: begin
        cmd.emit_init = 1'b1;
        state_next = stat.deadlock ? rdd_pkg::ST_EMIT : rdd_pkg::ST_EMIT_NONE;
      end
      rdd_pkg::ST_EMIT: begin
        if (!stat.cur_unf) begin
          cmd.p_advance = 1'b1;
        end else if (stat.out_space) begin
          cmd.out_load  = 1'b1;
          cmd.out_found = 1'b1;
          if (stat.last_unf) begin
            state_next = rdd_pkg::ST_IDLE;
          end else begin
            cmd.p_advance = 1'b1;
          end
        end
      end
      rdd_pkg::ST_EMIT_NONE: begin
        if (stat.out_space) begin
          cmd.out_load = 1'b1;
          state_next = rdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/rdd_datapath.sv
// Datapath of the deadlock detector: tables, work vector, flags, counters,
// allocation RAM and output register. Depends on rdd_pkg and rdd_ram.
module rdd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  rdd_pkg::cmd_t                      cmd,
  output rdd_pkg::stat_t                     stat,
  input  logic [1:0]                         op,
  input  logic [rdd_pkg::P_BITS-1:0]         process_index,
  input  logic [rdd_pkg::R_BITS-1:0]         resource_index,
  input  logic [rdd_pkg::COUNT_BITS-1:0]     amount,
  input  logic                               request_valid,
  input  logic [rdd_pkg::CFG_BITS-1:0]       process_count,
  input  logic [rdd_pkg::CFG_BITS-1:0]       resource_count,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [rdd_pkg::P_BITS-1:0]         deadlocked_process,
  output logic                               deadlock_found,
  output logic                               last
);

  localparam int PN = rdd_pkg::PROC_NUM;
  localparam int RN = rdd_pkg::RES_NUM;
  localparam int CB = rdd_pkg::COUNT_BITS;
  localparam int UB = rdd_pkg::USED_BITS;

  logic [CB-1:0]                 total [RN];
  logic [rdd_pkg::REQ_BITS-1:0]  req   [PN];
  logic [CB-1:0]                 work  [RN];
  logic [PN-1:0]                 finished;
  logic [PN-1:0]                 holds;
  logic                          changed;
  logic [rdd_pkg::P_BITS-1:0]    p_cnt;
  logic [rdd_pkg::R_BITS-1:0]    r_cnt;
  logic [UB-1:0]                 used;

  // tag of the RAM read in flight
  logic                          tag_valid;
  logic                          tag_rel;
  logic [rdd_pkg::P_BITS-1:0]    tag_p;
  logic [rdd_pkg::R_BITS-1:0]    tag_r;
  logic                          tag_first;
  logic                          tag_lastp;

  logic [CB-1:0]                 rd_data;
  logic [rdd_pkg::CFG_BITS-1:0]  np, nr;
  logic [rdd_pkg::P_BITS-1:0]    np_m1;
  logic [rdd_pkg::R_BITS-1:0]    nr_m1;
  logic [UB-1:0]                 sum_total;
  logic [UB-1:0]                 total_ext;
  logic [CB-1:0]                 avail;
  logic [CB:0]                   rel_sum;
  logic [CB-1:0]                 rel_sat;
  logic [rdd_pkg::REQ_BITS-1:0]  cur_req;
  logic                          fits;
  logic [PN-1:0]                 unf;
  logic [PN-1:0]                 unf_upper;
  logic                          alloc_we;

  // Saturate the counts at the table sizes.
  assign np = (process_count > rdd_pkg::CFG_BITS'(PN)) ? rdd_pkg::CFG_BITS'(PN)
                                                       : process_count;
  assign nr = (resource_count > rdd_pkg::CFG_BITS'(RN)) ? rdd_pkg::CFG_BITS'(RN)
                                                        : resource_count;
  assign np_m1 = rdd_pkg::P_BITS'(np - rdd_pkg::CFG_BITS'(1));
  assign nr_m1 = rdd_pkg::R_BITS'(nr - rdd_pkg::CFG_BITS'(1));

  assign alloc_we = cmd.load && (rdd_pkg::op_t'(op) == rdd_pkg::OP_SET_ALLOC);

  rdd_ram #(
    .WIDTH (CB),
    .DEPTH (rdd_pkg::TABLE_DEPTH)
  ) u_alloc (
    .clk     (clk),
    .wr_en   (alloc_we),
    .wr_addr ({process_index, resource_index}),
    .wr_data (amount),
    .rd_en   (cmd.sum_issue || cmd.rel_issue),
    .rd_addr ({p_cnt, r_cnt}),
    .rd_data (rd_data)
  );

  // Column sum and available count.
  assign sum_total = (tag_first ? '0 : used) + UB'(rd_data);
  assign total_ext = UB'(total[tag_r]);
  assign avail     = (total_ext > sum_total) ? CB'(total_ext - sum_total) : '0;

  // Release adds with saturation.
  assign rel_sum = {1'b0, work[tag_r]} + {1'b0, rd_data};
  assign rel_sat = rel_sum[CB] ? rdd_pkg::COUNT_MAX : rel_sum[CB-1:0];

  // A missing request, or one outside the counted resources, always fits.
  assign cur_req = req[p_cnt];
  assign fits = !cur_req[rdd_pkg::R_BITS]
             || ({1'b0, cur_req[rdd_pkg::R_BITS-1:0]} >= nr)
             || (work[cur_req[rdd_pkg::R_BITS-1:0]] != '0);

  assign unf       = ~finished;
  assign unf_upper = unf >> p_cnt;

  always_comb begin
    stat           = '0;
    stat.np_zero   = (np == '0);
    stat.nr_zero   = (nr == '0);
    stat.sum_last  = (p_cnt == np_m1) && (r_cnt == nr_m1);
    stat.candidate = !finished[p_cnt] && fits;
    stat.r_last    = (r_cnt == nr_m1);
    stat.p_last    = (p_cnt == np_m1);
    stat.changed   = changed;
    // two or more unfinished: clearing the lowest set bit leaves some bit
    stat.deadlock  = (unf & (unf - PN'(1))) != '0;
    stat.cur_unf   = unf[p_cnt];
    stat.last_unf  = (unf_upper >> 1) == '0;
    stat.out_space = !m_tvalid || m_tready;
  end

  // Load tables.
  always_ff @(posedge clk) begin
    if (cmd.load && (rdd_pkg::op_t'(op) == rdd_pkg::OP_SET_TOTAL)) begin
      total[resource_index] <= amount;
    end
    if (cmd.load && (rdd_pkg::op_t'(op) == rdd_pkg::OP_SET_REQ)) begin
      req[process_index] <= {request_valid, resource_index};
    end
  end

  // Counters, flags and work vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      work      <= '{default: '0};
      finished  <= '0;
      holds     <= '0;
      changed   <= 1'b0;
      p_cnt     <= '0;
      r_cnt     <= '0;
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= cmd.sum_issue || cmd.rel_issue;
      tag_rel   <= cmd.rel_issue;
      tag_p     <= p_cnt;
      tag_r     <= r_cnt;
      tag_first <= (p_cnt == '0);
      tag_lastp <= (p_cnt == np_m1);

      if (cmd.run_start) begin
        work     <= '{default: '0};
        finished <= '0;
        holds    <= '0;
        changed  <= 1'b0;
        p_cnt    <= '0;
        r_cnt    <= '0;
      end

      // retire a RAM read
      if (tag_valid && !tag_rel) begin
        used <= sum_total;
        if (rd_data != '0) begin
          holds[tag_p] <= 1'b1;
        end
        if (tag_lastp) begin
          work[tag_r] <= avail;
        end
      end
      if (tag_valid && tag_rel) begin
        work[tag_r] <= rel_sat;
      end

      // sum walk: process inner, resource outer
      if (cmd.sum_issue) begin
        if (p_cnt == np_m1) begin
          p_cnt <= '0;
          r_cnt <= r_cnt + 1'b1;
        end else begin
          p_cnt <= p_cnt + 1'b1;
        end
      end

      if (cmd.mark) begin
        for (int i = 0; i < PN; i++) begin
          finished[i] <= (i >= int'(np)) || !holds[i];
        end
        p_cnt   <= '0;
        changed <= 1'b0;
      end

      if (cmd.scan && stat.candidate) begin
        finished[p_cnt] <= 1'b1;
        changed         <= 1'b1;
        r_cnt           <= '0;
      end

      if (cmd.rel_issue) begin
        r_cnt <= r_cnt + 1'b1;
      end

      if (cmd.p_advance) begin
        p_cnt <= p_cnt + 1'b1;
      end

      if (cmd.pass_restart) begin
        p_cnt   <= '0;
        changed <= 1'b0;
      end

      if (cmd.emit_init) begin
        p_cnt <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      deadlock_found     <= cmd.out_found;
      deadlocked_process <= cmd.out_found ? p_cnt : '0;
      last               <= cmd.out_found ? stat.last_unf : 1'b1;
    end
  end

endmodule

>>> design/resource_deadlock_detector_core.sv
// Top level of the resource deadlock detector: stream ports, APB register
// file, controller and datapath. Depends on rdd_pkg, rdd_ctrl, rdd_datapath.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the operation (set
//   resource total, set allocation, set request, run detection), s_tdata the
//   indexes, amount and request flag. Load requests are taken one per cycle
//   while idle and give no result. A run request walks the stored tables and
//   gives one or more results on the m_ stream: m_tuser is the deadlock flag,
//   m_tdata the deadlocked process index, m_tlast closes the run.
// Steps of a run (np, nr the saturated counts): the column sums through
//   the allocation RAM's single read port, the release passes over the
//   np processes, each release reading nr allocations, then the count of
//   the unfinished processes and the emit walk over the process indexes,
//   which waits on any receiver stall. s_tready stays low for the whole run
//   and rises once the last result is in the output register.
// A stalled receiver holds the current result in the output register; the
//   emit walk waits for it, and after the final result the block takes new
//   requests while that result still waits.
// Reset clears the counts, the work vector, the finished flags and the
//   handshake state; the resource, allocation and request tables are not
//   cleared and must be loaded before a run reads them.
// Registers (APB, byte address 4*i): 0 process_count, 1 resource_count.
module resource_deadlock_detector_core (
  input  logic                             clk,
  input  logic                             rst,
  // slave stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // {pad[23:17], request_valid[16], amount[15:8], resource_index[7:4],
  //  process_index[3:0]}
  input  logic [23:0]                      s_tdata,
  // {operation[1:0]}
  input  logic [1:0]                       s_tuser,
  // master stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // {pad[7:4], deadlocked_process[3:0]}
  output logic [7:0]                       m_tdata,
  // {deadlock_found[0]}
  output logic                             m_tuser,
  output logic                             m_tlast,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [rdd_pkg::CFG_BITS-1:0] process_count;
  logic [rdd_pkg::CFG_BITS-1:0] resource_count;
  logic [rdd_pkg::P_BITS-1:0]   deadlocked_process;
  rdd_pkg::cmd_t                cmd;
  rdd_pkg::stat_t               stat;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register file: the register index sits in paddr[2].
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= '0;
      resource_count <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == rdd_pkg::REG_PROCESS_COUNT) begin
        process_count <= pwdata[rdd_pkg::CFG_BITS-1:0];
      end else begin
        resource_count <= pwdata[rdd_pkg::CFG_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rdd_pkg::REG_RESOURCE_COUNT) begin
      prdata = 32'(resource_count);
    end else begin
      prdata = 32'(process_count);
    end
  end

  rdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rdd_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .op                 (s_tuser),
    .process_index      (s_tdata[3:0]),
    .resource_index     (s_tdata[7:4]),
    .amount             (s_tdata[15:8]),
    .request_valid      (s_tdata[16]),
    .process_count      (process_count),
    .resource_count     (resource_count),
    .m_tready           (m_tready),
    .m_tvalid           (m_tvalid),
    .deadlocked_process (deadlocked_process),
    .deadlock_found     (m_tuser),
    .last               (m_tlast)
  );

  // Pad the result to a whole byte.
  assign m_tdata = 8'(deadlocked_process);

endmodule
